// File: src/tlbs_pkg.sv
// ----------------------------------------------------------------------------
// tlbs_pkg
// Shared types and codes for the searchable entry table.
// ----------------------------------------------------------------------------
package tlbs_pkg;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_LINEAR = 2'd1;
   localparam logic [1:0] OP_BINARY = 2'd2;

   localparam logic [4:0] COUNT_RESET = 5'd16;

   typedef struct packed {
      logic [1:0]         operation;
      logic [3:0]         entry_index;
      logic signed [31:0] entry_value;
      logic signed [31:0] search_key;
   } req_word_type;

   typedef struct packed {
      logic       found;
      logic [3:0] match_index;
   } rsp_word_type;

   // compare of the registered table word against the key
   typedef struct packed {
      logic hit;
      logic key_less;
   } cmp_type;

endpackage

// File: src/table_linear_binary_search_top.sv
// ----------------------------------------------------------------------------
// table_linear_binary_search_top
// Table of signed 32-bit entries with write, linear search and binary search.
// ----------------------------------------------------------------------------
//  channel  | ports                          | direction
//  ---------+--------------------------------+----------
//  request  | req_valid, req_stall, req_word | in
//  response | rsp_valid, rsp_stall, rsp_word | out
//  csr      | csr_write_enable, csr_write_data | in
//
//  write or unused code: the word goes straight to S_DONE, which loads the response register
//  linear search: one memory read a cycle over the active count of entries
//  binary search: each probe reads through the single read port, then compares
//  reset restores entry_count to 16; table contents are undefined until written
//  one response register; a new word is accepted while a response waits,
//  and its result is held until the register frees
// ----------------------------------------------------------------------------
module table_linear_binary_search_top #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tlbs_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tlbs_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write_enable,
   input  logic [4:0]             csr_write_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_LSCAN = 5'b00010,
      S_BREAD = 5'b00100,
      S_BCMP  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [4:0]            count_ff, count_in;
   logic signed [31:0]    key_ff, key_in;
   logic [CNT_W-1:0]      ptr_ff, ptr_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic                  chk_ff, chk_in;
   logic [CNT_W-1:0]      lo_ff, lo_in;
   logic [CNT_W-1:0]      hi_ff, hi_in;
   logic                  res_found_ff, res_found_in;
   logic [3:0]            res_idx_ff, res_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tlbs_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                  accept;
   logic [CNT_W-1:0]      n_active;
   logic [CNT_W:0]        mid_sum;
   logic [CNT_W-1:0]      mid;
   logic [CNT_W-1:0]      next_lo;
   logic [CNT_W-1:0]      next_hi;
   logic                  wr_en;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   tlbs_pkg::cmp_type     cmp;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // active count saturated to the table depth
   assign n_active = (32'(count_ff) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(count_ff);

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - (CNT_W + 1)'(1);
   assign mid     = mid_sum[CNT_W:1];
   assign next_lo = cmp.key_less ? lo_ff : (CNT_W'(pos_ff) + CNT_W'(1));
   assign next_hi = cmp.key_less ? CNT_W'(pos_ff) : hi_ff;

   assign count_in = csr_write_enable ? csr_write_data : count_ff;

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      chk_in       = chk_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      res_found_in = res_found_ff;
      res_idx_in   = res_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in       = req_word.search_key;
               res_found_in = 1'b0;
               res_idx_in   = 4'd0;
               ptr_in       = '0;
               chk_in       = 1'b0;
               lo_in        = '0;
               hi_in        = n_active;
               unique case (req_word.operation)
                  tlbs_pkg::OP_WRITE: begin
                     wr_en    = (32'(req_word.entry_index) < TABLE_DEPTH);
                     state_in = S_DONE;
                  end
                  tlbs_pkg::OP_LINEAR: begin
                     state_in = S_LSCAN;
                  end
                  tlbs_pkg::OP_BINARY: begin
                     state_in = (n_active == '0) ? S_DONE : S_BREAD;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_LSCAN: begin
            if (chk_ff && cmp.hit) begin
               res_found_in = 1'b1;
               res_idx_in   = 4'(pos_ff);
               state_in     = S_DONE;
            end else if (ptr_ff < n_active) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[IDX_W-1:0];
               pos_in  = ptr_ff[IDX_W-1:0];
               chk_in  = 1'b1;
               ptr_in  = ptr_ff + CNT_W'(1);
            end else begin
               state_in = S_DONE;
            end
         end
         S_BREAD: begin
            rd_en    = 1'b1;
            rd_addr  = mid[IDX_W-1:0];
            pos_in   = mid[IDX_W-1:0];
            state_in = S_BCMP;
         end
         S_BCMP: begin
            if (cmp.hit) begin
               res_found_in = 1'b1;
               res_idx_in   = 4'(pos_ff);
               state_in     = S_DONE;
            end else begin
               lo_in    = next_lo;
               hi_in    = next_hi;
               state_in = (next_lo < next_hi) ? S_BREAD : S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.found       = res_found_ff;
               rsp_word_in.match_index = res_idx_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= tlbs_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         chk_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_ff       <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      ptr_ff       <= ptr_in;
      pos_ff       <= pos_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      res_found_ff <= res_found_in;
      res_idx_ff   <= res_idx_in;
      rsp_word_ff  <= rsp_word_in;
   end

   tlbs_table #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(IDX_W'(req_word.entry_index)),
      .wr_data(req_word.entry_value),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .key    (key_ff),
      .cmp    (cmp)
   );

   // a miss always reports index zero
   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_word_ff.found |-> rsp_word_ff.match_index == 4'd0)
      else $error("miss response with nonzero index");

   // a write or unused code goes straight to the result with no hit
   a_write_no_hit: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.operation != tlbs_pkg::OP_LINEAR &&
      req_word.operation != tlbs_pkg::OP_BINARY |=> state_ff == S_DONE && !res_found_ff)
      else $error("write produced a hit or entered a search");

   // scan pointer never runs past the active count
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LSCAN |-> ptr_ff <= n_active)
      else $error("linear scan pointer beyond active count");

   // a probe is only issued on a nonempty range
   a_probe_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_BREAD |-> lo_ff < hi_ff && hi_ff <= n_active)
      else $error("binary probe on empty or oversized range");

endmodule

// File: src/tlbs_table.sv
// ----------------------------------------------------------------------------
// tlbs_table
// Entry memory with one write port and one registered read port, plus the
// equal and signed-less compare of the read word against the search key.
// ----------------------------------------------------------------------------
module tlbs_table #(
   parameter int TABLE_DEPTH = 16,
   parameter int IDX_W       = 4
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic signed [31:0] wr_data,
   input  logic               rd_en,
   input  logic [IDX_W-1:0]   rd_addr,
   input  logic signed [31:0] key,
   output tlbs_pkg::cmp_type  cmp
);

   logic signed [31:0] mem [TABLE_DEPTH];
   logic signed [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      cmp.hit      = (rd_data_ff == key);
      cmp.key_less = (key < rd_data_ff);
   end

endmodule

// File: dv/tlbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbs_checker
// Watches the request, response and csr ports of the entry table, keeps its
// own copy of the table and the entry count, predicts one response word per
// accepted request word and compares each accepted response in order.
// ----------------------------------------------------------------------------
module tlbs_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  tlbs_pkg::req_word_type req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  tlbs_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write_enable,
   input  logic [4:0]             csr_write_data,
   output int                     fail_count,
   output int                     pending,
   output int                     hit_count
);

   localparam int DEPTH = 16;

   logic signed [31:0]     entry_mem [DEPTH];
   logic [4:0]             count_reg = tlbs_pkg::COUNT_RESET;
   tlbs_pkg::rsp_word_type pending_lookups [$];
   int                     errors = 0;
   int                     hits = 0;

   function automatic tlbs_pkg::rsp_word_type lookup_result(input tlbs_pkg::req_word_type w);
      tlbs_pkg::rsp_word_type r;
      int           n;
      int           i;
      int           lo;
      int           hi;
      int           mid;
      r = '0;
      n = (count_reg > DEPTH) ? DEPTH : int'(count_reg);
      if (w.operation == tlbs_pkg::OP_LINEAR) begin
         i = 0;
         while (i < n && !r.found) begin
            if (entry_mem[i] == w.search_key) begin
               r.found       = 1'b1;
               r.match_index = 4'(i);
            end
            i++;
         end
      end else if (w.operation == tlbs_pkg::OP_BINARY) begin
         lo = 0;
         hi = n;
         while (lo < hi && !r.found) begin
            mid = (lo + hi - 1) / 2;
            if (entry_mem[mid] == w.search_key) begin
               r.found       = 1'b1;
               r.match_index = 4'(mid);
            end else if (w.search_key < entry_mem[mid]) begin
               hi = mid;
            end else begin
               lo = mid + 1;
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      tlbs_pkg::rsp_word_type want;
      if (reset) begin
         count_reg = tlbs_pkg::COUNT_RESET;
         pending_lookups.delete();
      end else begin
         if (csr_write_enable) begin
            count_reg = csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_lookups.size() == 0) begin
               $error("response word with nothing expected: found %0d match_index %0d",
                      rsp_word.found, rsp_word.match_index);
               errors++;
            end else begin
               want = pending_lookups.pop_front();
               if (rsp_word.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_word.found);
                  errors++;
               end
               if (rsp_word.match_index !== want.match_index) begin
                  $error("match_index: expected %0d, actual %0d",
                         want.match_index, rsp_word.match_index);
                  errors++;
               end
               if (want.found) begin
                  hits++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_word.operation == tlbs_pkg::OP_WRITE) begin
               entry_mem[req_word.entry_index] = req_word.entry_value;
            end
            pending_lookups.push_back(lookup_result(req_word));
         end
      end
      fail_count <= errors;
      pending    <= pending_lookups.size();
      hit_count  <= hits;
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the entry table with a directed set of writes and searches at the
// field and count extremes, then with phases of sorted and unsorted tables
// searched by linear and binary lookups, under bursty requests, random
// response stalls and one long response hold-off.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         DIRECTED     = 25;
   localparam int         RANDOM_ITEMS = 1800;
   localparam int         HOLD_CYCLES  = 300;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   tlbs_pkg::req_word_type req_word         = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   tlbs_pkg::rsp_word_type rsp_word;
   logic                   csr_write_enable = 1'b0;
   logic [4:0]             csr_write_data   = '0;
   logic                   hold_ask         = 1'b0;

   int fail_count;
   int pending;
   int hit_count;
   int sent_count   = 0;
   int burst_left   = 0;
   int count_writes = 0;

   logic signed [31:0] shadow [16];

   table_linear_binary_search_top #(
      .TABLE_DEPTH(16)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_word        (rsp_word),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   tlbs_checker u_lookup_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_word        (rsp_word),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .hit_count       (hit_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic tlbs_pkg::req_word_type make_word(input logic [1:0] op,
                                                        input logic [3:0] idx,
                                                        input logic signed [31:0] val,
                                                        input logic signed [31:0] key);
      tlbs_pkg::req_word_type w;
      w.operation   = op;
      w.entry_index = idx;
      w.entry_value = val;
      w.search_key  = key;
      return w;
   endfunction

   // mostly keys present in the table, some neighbors, some anything
   function automatic logic signed [31:0] pick_key();
      logic signed [31:0] k;
      k = shadow[$urandom_range(0, 15)];
      case ($urandom_range(0, 5))
         0: k = k + 1;
         1: k = k - 1;
         2: k = $urandom();
         default: ;
      endcase
      return k;
   endfunction

   task automatic offer(input tlbs_pkg::req_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      sent_count++;
      if (w.operation == tlbs_pkg::OP_WRITE) begin
         shadow[w.entry_index] = w.entry_value;
      end
   endtask

   task automatic set_count(input logic [4:0] value);
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      count_writes++;
   endtask

   // response side stall pattern, plus one long hold-off on request
   initial begin
      int run_left;
      int hold_left;
      int pick;
      bit held;
      run_left  = 0;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ask && !held) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
            run_left  = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (run_left > 0) begin
            run_left--;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
               rsp_stall <= 1'b0;
               run_left = $urandom_range(20, 120);
            end else if (pick < 6) begin
               rsp_stall <= 1'b1;
               run_left = $urandom_range(0, 5);
            end else begin
               rsp_stall <= 1'b0;
               run_left = $urandom_range(0, 7);
            end
         end
      end
   end

   initial begin
      int                 vals [16];
      int                 order [16];
      int                 phase;
      int                 choice;
      int                 j;
      int                 tmp;
      bit                 narrow;
      logic signed [31:0] v;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sorted table holding both extremes of the value range
      for (int i = 0; i < 16; i++) begin
         v = (i == 0) ? 32'sh8000_0000 : (i == 15) ? 32'sh7fff_ffff : 32'(i * 1000 - 7000);
         offer(make_word(tlbs_pkg::OP_WRITE, 4'(i), v, ~v));
      end
      offer(make_word(tlbs_pkg::OP_LINEAR, 4'd3, 32'sd0, 32'sh7fff_ffff));
      offer(make_word(tlbs_pkg::OP_LINEAR, 4'd0, 32'sd0, 32'sd12345));
      offer(make_word(tlbs_pkg::OP_BINARY, 4'hf, '1, 32'sh8000_0000));
      offer(make_word(tlbs_pkg::OP_BINARY, 4'd0, '1, 32'sh7fff_ffff));
      offer(make_word(tlbs_pkg::OP_BINARY, 4'd7, 32'sd0, 32'sd500));
      offer(make_word(OP_UNUSED, 4'hf, 32'sh7fff_ffff, 32'sh7fff_ffff));
      // empty search range
      set_count(5'd0);
      offer(make_word(tlbs_pkg::OP_LINEAR, 4'd0, 32'sd0, 32'sh8000_0000));
      offer(make_word(tlbs_pkg::OP_BINARY, 4'd0, 32'sd0, 32'sh8000_0000));
      // count past the table depth
      set_count(5'd31);
      offer(make_word(tlbs_pkg::OP_BINARY, 4'd0, 32'sd0, 32'sh7fff_ffff));

      phase = 0;
      while (sent_count < DIRECTED + RANDOM_ITEMS) begin
         phase++;
         if (phase % 3 == 1) begin
            case ($urandom_range(0, 5))
               0: set_count(5'd0);
               1: set_count(5'd1);
               2: set_count(5'd16);
               3: set_count(5'd31);
               4: set_count(5'($urandom_range(2, 15)));
               default: set_count(5'($urandom_range(17, 30)));
            endcase
         end
         if (phase == 12) begin
            hold_ask <= 1'b1;
            burst_left = 60;
         end

         narrow = ($urandom_range(0, 2) == 0);
         for (int i = 0; i < 16; i++) begin
            vals[i]  = narrow ? int'($urandom_range(0, 16)) - 8 : int'($urandom());
            order[i] = i;
         end
         if ($urandom_range(0, 3) != 0) begin
            for (int i = 1; i < 16; i++) begin
               tmp = vals[i];
               j   = i - 1;
               while (j >= 0 && vals[j] > tmp) begin
                  vals[j + 1] = vals[j];
                  j--;
               end
               vals[j + 1] = tmp;
            end
         end
         for (int i = 15; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
         end
         for (int i = 0; i < 16; i++) begin
            offer(make_word(tlbs_pkg::OP_WRITE, 4'(order[i]), vals[order[i]], $urandom()));
         end

         repeat ($urandom_range(20, 60)) begin
            choice = $urandom_range(0, 19);
            if (choice == 0) begin
               offer(make_word(tlbs_pkg::OP_WRITE, 4'($urandom()), $urandom(), $urandom()));
            end else if (choice == 1) begin
               offer(make_word(OP_UNUSED, 4'($urandom()), $urandom(), $urandom()));
            end else begin
               offer(make_word(choice[0] ? tlbs_pkg::OP_LINEAR : tlbs_pkg::OP_BINARY,
                               4'($urandom()), $urandom(), pick_key()));
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d request words over %0d table phases, %0d searches hit",
               sent_count, phase, hit_count);
      $display("%0d entry_count writes, sorted and unsorted tables, one long response hold-off",
               count_writes);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
